// ===== hdl/power_soft_clipper_macros.svh =====
// Assertion macros shared by the power soft clipper checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef POWER_SOFT_CLIPPER_MACROS_SVH
`define POWER_SOFT_CLIPPER_MACROS_SVH

// Property checked on every rising edge outside reset.
`define PSC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PSC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/psc_pkg.sv =====
// Package of the power soft clipper: widths, modes, request structs and
// constant functions for the log2 and root tables. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int FRAC_BITS       = 20;
   localparam int MAG_W           = 21;
   localparam int LOG_STEPS       = 24;
   localparam int ROOT_COUNT      = 24;
   localparam int QUEUE_DEPTH     = 2;
   localparam logic [MAG_W-1:0] ONE_Q20 = 21'h100000;
   localparam longint unsigned LN2_Q30 = 64'd744261118;

   // How the magnitude is shaped.
   typedef enum logic [1:0] {
      MODE_HARD,
      MODE_TABLE,
      MODE_POWER,
      MODE_ZERO
   } mode_type;

   // Everything a request carries along the back pipeline.
   typedef struct packed {
      logic             neg;
      mode_type         mode;
      logic [MAG_W-1:0] mag_a;
      logic [15:0]      shape;
      logic [MAG_W-1:0] mag;
   } side_type;

   // A classified request as it waits in the queue.
   typedef struct packed {
      side_type    side;
      logic [30:0] mant;
      logic [4:0]  msb;
   } front_item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // Floor square root of a 64-bit value.
   function automatic longint unsigned isqrt64(input longint unsigned x);
      longint unsigned xv;
      longint unsigned res;
      longint unsigned b;
      xv  = x;
      res = 0;
      b   = 64'd1 << 62;
      while (b > xv) b = b >> 2;
      while (b != 0) begin
         if (xv >= res + b) begin
            xv  = xv - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // The root 2^(-2^-k) in Q30.
   function automatic longint unsigned root_q30(input int k);
      longint unsigned r;
      r = isqrt64(64'd1 << 59);
      for (int j = 2; j <= k; j++) r = isqrt64(r << 30);
      return r;
   endfunction

   // -log2(v / 2^20) in Q24, by repeated squaring.
   function automatic longint unsigned neglog2_q24(input longint unsigned v);
      longint unsigned m;
      longint unsigned frac;
      int              p;
      p    = 0;
      frac = 0;
      if (v == 0 || v >= 64'd1048576) return 0;
      while ((v >> (p + 1)) != 0) p++;
      m = v << (30 - p);
      for (int i = 0; i < LOG_STEPS; i++) begin
         m    = (m * m + (64'd1 << 29)) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(20 - p) << 24) - frac;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/power_soft_clipper.sv =====
// Power soft clipper, one audio sample per request, one result per request.
// Requests enter on req_valid / req_stall with req_sample_in (Q20) and
// req_shape_amount (Q16); results leave on rsp_valid / rsp_stall as
// rsp_sample_out (Q20, within -1.0 .. 1.0).
// A shape at or below zero gives a hard clip, at or above one the curve
// x(1 - ln x) from a table, and in between the power curve.
// The pipeline depth is set by the 24-step log2 and exp2 pipelines and the
// two pipelined dividers of 30 and 22 stages.
// Throughput is one request per cycle while the receiver takes results.
// A stalled result holds rsp_sample_out and freezes the back pipeline; the
// front register and a two-entry queue still take requests until full,
// after which req_stall rises.
// Reset empties the pipeline and queue; the curve table is a ROM and needs
// no filling. Depends on psc_pkg, psc_front, psc_queue and psc_back.
`timescale 1ns / 1ps
`default_nettype none
module power_soft_clipper #(
   parameter int TABLE_DEPTH = psc_pkg::TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_sample_in,
   input  logic signed [20:0] req_shape_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [21:0] rsp_sample_out
);
   import psc_pkg::*;

   queue_status_type q_status;
   front_item_type   push_item;
   front_item_type   head_item;
   logic             push;
   logic             pop;

   // Clamp and classify.
   psc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_shape_amount (req_shape_amount),
      .q_status         (q_status),
      .push             (push),
      .push_item        (push_item)
   );

   // Decouple front and back.
   psc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // Curve evaluation.
   psc_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
`default_nettype wire

// ===== hdl/psc_front.sv =====
// Front end of the power soft clipper: takes a request, clamps and
// classifies it and hands it to the queue. Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [23:0]        req_sample_in,
   input  logic signed [20:0]        req_shape_amount,
   input  psc_pkg::queue_status_type q_status,
   output logic                      push,
   output psc_pkg::front_item_type   push_item
);
   import psc_pkg::*;

   logic           fr_vld_ff;
   logic           fr_vld_in;
   front_item_type fr_item_ff;
   front_item_type fr_item_in;
   logic           load;
   logic [23:0]    smp;
   logic [23:0]    a_raw;
   logic [20:0]    mag_a;
   logic [4:0]     msb;

   // The held request moves on whenever the queue has room.
   assign push      = fr_vld_ff && !q_status.full;
   assign req_stall = fr_vld_ff && q_status.full;
   assign load      = req_valid && !req_stall;
   assign fr_vld_in = load || (fr_vld_ff && !push);
   assign push_item = fr_item_ff;

   // Magnitude, clamped to one.
   assign smp   = req_sample_in;
   assign a_raw = req_sample_in[23] ? (~smp + 24'd1) : smp;
   assign mag_a = (a_raw > 24'(ONE_Q20)) ? ONE_Q20 : a_raw[20:0];

   // Leading one of the magnitude below one, for the log normalisation.
   always_comb begin
      msb = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (mag_a[i]) msb = 5'(i);
      end
   end

   // Classify the request by its shape amount.
   always_comb begin
      fr_item_in            = '0;
      fr_item_in.side.neg   = req_sample_in[23];
      fr_item_in.side.mag_a = mag_a;
      fr_item_in.side.shape = req_shape_amount[15:0];
      fr_item_in.msb        = msb;
      fr_item_in.mant       = 31'(mag_a[19:0]) << (5'd30 - msb);
      priority if (req_shape_amount[20] || req_shape_amount == 21'sd0) begin
         fr_item_in.side.mode = MODE_HARD;
         fr_item_in.side.mag  = mag_a;
      end else if (req_shape_amount[19:16] != 4'd0) begin
         fr_item_in.side.mode = MODE_TABLE;
      end else if (mag_a == '0) begin
         fr_item_in.side.mode = MODE_ZERO;
      end else begin
         fr_item_in.side.mode = MODE_POWER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else begin
         fr_vld_ff <= fr_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fr_item_ff <= fr_item_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/psc_queue.sv =====
// Two-entry queue between the front end and the back pipeline.
// Depends on psc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  psc_pkg::front_item_type   push_item,
   input  logic                      pop,
   output psc_pkg::front_item_type   head_item,
   output psc_pkg::queue_status_type q_status
);
   import psc_pkg::*;

   front_item_type q_mem_ff [QUEUE_DEPTH];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     cnt_ff;
   logic [1:0]     cnt_in;

   assign head_item          = q_mem_ff[rd_ptr_ff];
   assign q_status.not_empty = (cnt_ff != 2'd0);
   assign q_status.full      = (cnt_ff == 2'(QUEUE_DEPTH));

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/psc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit. Depends on psc_pkg only for style.
`timescale 1ns / 1ps
`default_nettype none
module psc_divider #(
   parameter int NUM_W  = 45,
   parameter int DEN_W  = 16,
   parameter int QUO_W  = 29,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [QUO_W-1:0]  out_quo,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);
   import psc_pkg::*;

   localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [QUO_W:0]    dv_vld_ff;
   logic [QUO_W:0]    dv_vld_in;
   logic [NUM_W-1:0]  dv_rem_ff  [QUO_W+1];
   logic [NUM_W-1:0]  dv_rem_in  [QUO_W+1];
   logic [QUO_W-1:0]  dv_quo_ff  [QUO_W+1];
   logic [QUO_W-1:0]  dv_quo_in  [QUO_W+1];
   logic [DEN_W-1:0]  dv_den_ff  [QUO_W+1];
   logic [DEN_W-1:0]  dv_den_in  [QUO_W+1];
   logic [QUO_W:0]    dv_ovf_ff;
   logic [QUO_W:0]    dv_ovf_in;
   logic [SIDE_W-1:0] dv_side_ff [QUO_W+1];
   logic [SIDE_W-1:0] dv_side_in [QUO_W+1];

   // Entry stage: capture and check that the quotient fits.
   assign dv_vld_in[0]  = in_vld;
   assign dv_rem_in[0]  = in_num;
   assign dv_quo_in[0]  = '0;
   assign dv_den_in[0]  = in_den;
   assign dv_side_in[0] = in_side;
   assign dv_ovf_in[0]  = CMP_W'(in_num) >= (CMP_W'(in_den) << QUO_W);

   // One trial subtraction per stage, most significant bit first.
   for (genvar i = 1; i <= QUO_W; i++) begin : g_step
      localparam int BIT_POS = QUO_W - i;
      logic [CMP_W-1:0] shifted;
      logic [CMP_W-1:0] rem_w;
      logic             ge;
      logic [QUO_W-1:0] q_set;
      assign shifted       = CMP_W'(dv_den_ff[i-1]) << BIT_POS;
      assign rem_w         = CMP_W'(dv_rem_ff[i-1]);
      assign ge            = rem_w >= shifted;
      assign q_set         = dv_quo_ff[i-1] | (QUO_W'(1) << BIT_POS);
      assign dv_rem_in[i]  = ge ? NUM_W'(rem_w - shifted) : dv_rem_ff[i-1];
      assign dv_quo_in[i]  = ge ? q_set : dv_quo_ff[i-1];
      assign dv_den_in[i]  = dv_den_ff[i-1];
      assign dv_ovf_in[i]  = dv_ovf_ff[i-1];
      assign dv_side_in[i] = dv_side_ff[i-1];
      assign dv_vld_in[i]  = dv_vld_ff[i-1];
   end

   assign out_vld  = dv_vld_ff[QUO_W];
   assign out_quo  = dv_quo_ff[QUO_W];
   assign out_ovf  = dv_ovf_ff[QUO_W];
   assign out_side = dv_side_ff[QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else if (adv) begin
         dv_vld_ff <= dv_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff  <= dv_rem_in;
         dv_quo_ff  <= dv_quo_in;
         dv_den_ff  <= dv_den_in;
         dv_ovf_ff  <= dv_ovf_in;
         dv_side_ff <= dv_side_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/psc_back.sv =====
// Back pipeline of the power soft clipper: log2, division, exp2, the curve
// table with interpolation and the output register. Depends on psc_pkg and
// psc_divider.
`timescale 1ns / 1ps
`default_nettype none
module psc_back #(
   parameter int TABLE_DEPTH = psc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  psc_pkg::queue_status_type q_status,
   input  psc_pkg::front_item_type   head_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [21:0]        rsp_sample_out
);
   import psc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int POS_W = FRAC_BITS + IDX_W;
   localparam int TB_LAT = 4;
   localparam int Q1_W = 29;
   localparam int Q2_W = 21;
   localparam int SIDE_W = $bits(side_type);
   localparam longint unsigned TAB_STEP  = 64'(TABLE_DEPTH - 2);
   localparam longint unsigned TAB_STEP2 = 64'(2 * (TABLE_DEPTH - 2));
   localparam logic [IDX_W-1:0] TAB_STEP_C = IDX_W'(TABLE_DEPTH - 2);
   localparam logic [61:0] HALF_SQ = 62'd1 << 29;
   localparam logic [60:0] HALF_EX = 61'd1 << 29;

   typedef logic [MAG_W-1:0] curve_rom_type [TABLE_DEPTH];

   // Samples of x(1 - ln x) at equal steps, with slack at the top end.
   function automatic curve_rom_type build_curve();
      curve_rom_type   rom;
      longint unsigned kk;
      longint unsigned x;
      longint unsigned n;
      longint unsigned e;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         kk = 64'(k);
         if (k == 0) begin
            rom[k] = '0;
         end else if (kk >= TAB_STEP) begin
            rom[k] = ONE_Q20;
         end else begin
            x = (kk * 64'd2097152 + TAB_STEP) / TAB_STEP2;
            n = (neglog2_q24(x) * LN2_Q30 + (64'd1 << 29)) >> 30;
            e = (x * ((64'd1 << 24) + n) + (64'd1 << 23)) >> 24;
            rom[k] = (e > 64'd1048576) ? ONE_Q20 : MAG_W'(e);
         end
      end
      return rom;
   endfunction

   localparam curve_rom_type CURVE_ROM = build_curve();

   logic adv;
   logic rsp_vld_ff;
   logic rsp_vld_in;
   logic [21:0] rsp_data_ff;
   logic [21:0] rsp_data_in;

   // The whole pipeline moves unless a result waits on a stalled receiver.
   assign adv            = !rsp_vld_ff || !rsp_stall;
   assign pop            = adv && q_status.not_empty;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_sample_out = rsp_data_ff;

   // ---------------------------------------------------------------- table
   logic [POS_W-1:0] tb_pos_ff;
   logic [POS_W-1:0] tb_pos_in;
   logic [IDX_W-1:0] tb_idx;
   logic [MAG_W-1:0] tb_t0_ff;
   logic [MAG_W-1:0] tb_t1_ff;
   logic [19:0]      tb_r_ff;
   logic [41:0]      tb_p0_ff;
   logic [41:0]      tb_p0_in;
   logic [41:0]      tb_p1_ff;
   logic [41:0]      tb_p1_in;
   logic [42:0]      tb_sum;
   logic [MAG_W-1:0] tb_mag_ff;
   logic [MAG_W-1:0] tb_mag_in;

   // Position in the table, then two neighbouring entries, then the blend.
   assign tb_pos_in = POS_W'(head_item.side.mag_a) * POS_W'(TAB_STEP_C);
   assign tb_idx    = tb_pos_ff[POS_W-1:FRAC_BITS];
   assign tb_p0_in  = 42'(tb_t0_ff) * 42'(ONE_Q20 - {1'b0, tb_r_ff});
   assign tb_p1_in  = 42'(tb_t1_ff) * 42'(tb_r_ff);
   assign tb_sum    = {1'b0, tb_p0_ff} + {1'b0, tb_p1_ff} + 43'h80000;
   assign tb_mag_in = tb_sum[40:20];

   always_ff @(posedge clock) begin
      if (adv) begin
         tb_pos_ff <= tb_pos_in;
         tb_t0_ff  <= CURVE_ROM[tb_idx];
         tb_t1_ff  <= CURVE_ROM[IDX_W'(tb_idx + 1'b1)];
         tb_r_ff   <= tb_pos_ff[FRAC_BITS-1:0];
         tb_p0_ff  <= tb_p0_in;
         tb_p1_ff  <= tb_p1_in;
         tb_mag_ff <= tb_mag_in;
      end
   end

   // -------------------------------------------------------------- log2
   logic [LOG_STEPS-1:0] lg_vld_ff;
   logic [LOG_STEPS-1:0] lg_vld_in;
   side_type             lg_side_ff [LOG_STEPS];
   side_type             lg_side_in [LOG_STEPS];
   logic [30:0]          lg_mant_ff [LOG_STEPS];
   logic [30:0]          lg_mant_in [LOG_STEPS];
   logic [23:0]          lg_frac_ff [LOG_STEPS];
   logic [23:0]          lg_frac_in [LOG_STEPS];
   logic [4:0]           lg_msb_ff  [LOG_STEPS];
   logic [4:0]           lg_msb_in  [LOG_STEPS];

   // One squaring per stage gives one fraction bit of the logarithm.
   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
      logic [30:0] m_prev;
      logic [23:0] f_prev;
      side_type    s_prev;
      side_type    s_fix;
      logic        v_prev;
      logic [4:0]  b_prev;
      logic [61:0] sq;
      logic [31:0] sh;
      if (k == 0) begin : g_first
         assign m_prev = head_item.mant;
         assign f_prev = '0;
         assign s_prev = head_item.side;
         assign v_prev = q_status.not_empty;
         assign b_prev = head_item.msb;
      end else begin : g_next
         assign m_prev = lg_mant_ff[k-1];
         assign f_prev = lg_frac_ff[k-1];
         assign s_prev = lg_side_ff[k-1];
         assign v_prev = lg_vld_ff[k-1];
         assign b_prev = lg_msb_ff[k-1];
      end
      // The table result joins its request here.
      always_comb begin
         s_fix = s_prev;
         if ((k == TB_LAT) && (s_prev.mode == MODE_TABLE)) s_fix.mag = tb_mag_ff;
      end
      assign sq            = 62'(m_prev) * 62'(m_prev) + HALF_SQ;
      assign sh            = sq[61:30];
      assign lg_mant_in[k] = sh[31] ? sh[31:1] : sh[30:0];
      assign lg_frac_in[k] = {f_prev[22:0], sh[31]};
      assign lg_side_in[k] = s_fix;
      assign lg_vld_in[k]  = v_prev;
      assign lg_msb_in[k]  = b_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_vld_ff <= '0;
      end else if (adv) begin
         lg_vld_ff <= lg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lg_side_ff <= lg_side_in;
         lg_mant_ff <= lg_mant_in;
         lg_frac_ff <= lg_frac_in;
         lg_msb_ff  <= lg_msb_in;
      end
   end

   // ---------------------------------------------------- log2 over shape
   side_type    ls_side;
   logic [28:0] ls_log;
   logic [44:0] ls_num;
   logic        d1_vld;
   logic [Q1_W-1:0] d1_quo;
   logic        d1_ovf;
   side_type    d1_side;

   assign ls_side = lg_side_ff[LOG_STEPS-1];
   assign ls_log  = (ls_side.mag_a == ONE_Q20) ? '0 :
                    ({5'd20 - lg_msb_ff[LOG_STEPS-1], 24'd0} -
                     {5'd0, lg_frac_ff[LOG_STEPS-1]});
   assign ls_num  = {ls_log, 16'd0};

   psc_divider #(
      .NUM_W  (45),
      .DEN_W  (16),
      .QUO_W  (Q1_W),
      .SIDE_W (SIDE_W)
   ) u_div_log (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (lg_vld_ff[LOG_STEPS-1]),
      .in_num   (ls_num),
      .in_den   (ls_side.shape),
      .in_side  (ls_side),
      .out_vld  (d1_vld),
      .out_quo  (d1_quo),
      .out_ovf  (d1_ovf),
      .out_side (d1_side)
   );

   // --------------------------------------------------------------- exp2
   logic [ROOT_COUNT-1:0] ex_vld_ff;
   logic [ROOT_COUNT-1:0] ex_vld_in;
   logic [ROOT_COUNT-1:0] ex_zero_ff;
   logic [ROOT_COUNT-1:0] ex_zero_in;
   side_type              ex_side_ff [ROOT_COUNT];
   side_type              ex_side_in [ROOT_COUNT];
   logic [30:0]           ex_r_ff    [ROOT_COUNT];
   logic [30:0]           ex_r_in    [ROOT_COUNT];
   logic [Q1_W-1:0]       ex_q_ff    [ROOT_COUNT];
   logic [Q1_W-1:0]       ex_q_in    [ROOT_COUNT];

   // One root multiplied in per set fraction bit.
   for (genvar k = 0; k < ROOT_COUNT; k++) begin : g_exp
      localparam logic [29:0] ROOT_K = 30'(root_q30(k + 1));
      logic [30:0]     r_prev;
      logic [Q1_W-1:0] q_prev;
      side_type        s_prev;
      logic            v_prev;
      logic            z_prev;
      logic [60:0]     prod;
      if (k == 0) begin : g_first
         assign r_prev = 31'h40000000;
         assign q_prev = d1_quo;
         assign s_prev = d1_side;
         assign v_prev = d1_vld;
         assign z_prev = d1_ovf || (d1_quo[Q1_W-1:24] == 5'd31);
      end else begin : g_next
         assign r_prev = ex_r_ff[k-1];
         assign q_prev = ex_q_ff[k-1];
         assign s_prev = ex_side_ff[k-1];
         assign v_prev = ex_vld_ff[k-1];
         assign z_prev = ex_zero_ff[k-1];
      end
      assign prod          = 61'(r_prev) * 61'(ROOT_K) + HALF_EX;
      assign ex_r_in[k]    = q_prev[23-k] ? prod[60:30] : r_prev;
      assign ex_q_in[k]    = q_prev;
      assign ex_side_in[k] = s_prev;
      assign ex_vld_in[k]  = v_prev;
      assign ex_zero_in[k] = z_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= '0;
      end else if (adv) begin
         ex_vld_ff <= ex_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_zero_ff <= ex_zero_in;
         ex_side_ff <= ex_side_in;
         ex_r_ff    <= ex_r_in;
         ex_q_ff    <= ex_q_in;
      end
   end

   // ------------------------------------------ scale, product, numerator
   logic        sp_vld_ff;
   side_type    sp_side_ff;
   logic [30:0] sp_p_ff;
   logic [30:0] sp_p_in;
   logic        mu_vld_ff;
   side_type    mu_side_ff;
   logic [46:0] mu_fp_ff;
   logic [46:0] mu_fp_in;
   logic        nd_vld_ff;
   side_type    nd_side_ff;
   logic [47:0] nd_num_ff;
   logic [47:0] nd_num_in;
   logic [26:0] nd_den_ff;
   logic [26:0] nd_den_in;
   logic [46:0] lhs;
   logic [46:0] num;
   logic [16:0] dd;

   // Integer part of the exponent as a right shift.
   assign sp_p_in  = ex_zero_ff[ROOT_COUNT-1] ? '0 :
                     (ex_r_ff[ROOT_COUNT-1] >> ex_q_ff[ROOT_COUNT-1][Q1_W-1:24]);
   assign mu_fp_in = 47'(sp_side_ff.shape) * 47'(sp_p_ff);

   // Numerator with rounding half of the divisor, and the divisor itself.
   assign lhs       = {mu_side_ff.mag_a, 26'd0};
   assign num       = (lhs > mu_fp_ff) ? (lhs - mu_fp_ff) : '0;
   assign dd        = 17'h10000 - {1'b0, mu_side_ff.shape};
   assign nd_num_in = {1'b0, num} + (48'(dd) << 9);
   assign nd_den_in = {dd, 10'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_vld_ff <= 1'b0;
         mu_vld_ff <= 1'b0;
         nd_vld_ff <= 1'b0;
      end else if (adv) begin
         sp_vld_ff <= ex_vld_ff[ROOT_COUNT-1];
         mu_vld_ff <= sp_vld_ff;
         nd_vld_ff <= mu_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_side_ff <= ex_side_ff[ROOT_COUNT-1];
         sp_p_ff    <= sp_p_in;
         mu_side_ff <= sp_side_ff;
         mu_fp_ff   <= mu_fp_in;
         nd_side_ff <= mu_side_ff;
         nd_num_ff  <= nd_num_in;
         nd_den_ff  <= nd_den_in;
      end
   end

   logic            d2_vld;
   logic [Q2_W-1:0] d2_quo;
   logic            d2_ovf;
   side_type        d2_side;

   psc_divider #(
      .NUM_W  (48),
      .DEN_W  (27),
      .QUO_W  (Q2_W),
      .SIDE_W (SIDE_W)
   ) u_div_out (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (nd_vld_ff),
      .in_num   (nd_num_ff),
      .in_den   (nd_den_ff),
      .in_side  (nd_side_ff),
      .out_vld  (d2_vld),
      .out_quo  (d2_quo),
      .out_ovf  (d2_ovf),
      .out_side (d2_side)
   );

   // ------------------------------------------------------------- output
   logic [MAG_W-1:0] pow_mag;
   logic [MAG_W-1:0] fin_mag;
   logic [21:0]      mag22;

   // Saturate the power result, choose by mode and restore the sign.
   assign pow_mag     = (d2_ovf || (d2_quo > ONE_Q20)) ? ONE_Q20 : d2_quo;
   assign fin_mag     = (d2_side.mode == MODE_POWER) ? pow_mag : d2_side.mag;
   assign mag22       = {1'b0, fin_mag};
   assign rsp_data_in = d2_side.neg ? (~mag22 + 22'd1) : mag22;
   assign rsp_vld_in  = d2_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/psc_checker.sv =====
// Port-level checks of the power soft clipper, bound to its top level.
// Depends on power_soft_clipper_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "power_soft_clipper_macros.svh"
module psc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [21:0] rsp_sample_out
);

   logic [7:0] cnt_ff;
   logic [7:0] cnt_in;

   // Requests accepted and not yet delivered.
   assign cnt_in = cnt_ff + 8'(req_valid && !req_stall) - 8'(rsp_valid && !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 8'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `PSC_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out), "stalled result changed")
   `PSC_ASSERT_RST(a_no_orphan, clock, reset, rsp_valid |-> cnt_ff != 8'd0, "result without a request")
   `PSC_ASSERT(a_rst_quiet, clock, $past(reset) |-> !rsp_valid && !req_stall, "busy after reset")
   `PSC_ASSERT_RST(a_range, clock, reset, rsp_valid |-> (rsp_sample_out <= 22'sd1048576) && (rsp_sample_out >= -22'sd1048576), "result out of range")

endmodule

bind power_soft_clipper psc_checker u_psc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of power_soft_clipper: directed extremes, random samples in every
// shape mode under several idling mixes, and a long result hold-off. Depends on psc_pkg and
// the RTL of the clipper; the expected magnitudes are worked out here in fixed point.
`timescale 1ns / 1ps
module testbench;
   import psc_pkg::*;

   localparam int CURVE_DEPTH = 1024;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 160;
   localparam longint unsigned UNIT_Q20 = 64'd1048576;
   localparam longint unsigned UNIT_Q16 = 64'd65536;
   localparam longint unsigned LOG_E2_Q30 = 64'd744261118;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [23:0] req_sample_in;
   logic signed [20:0] req_shape_amount;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [21:0] rsp_sample_out;

   longint unsigned    curve_rom [CURVE_DEPTH];
   longint unsigned    half_roots [25];
   logic signed [21:0] clipped_due [$];
   int                 send_idle_pct;
   int                 rsp_stall_pct;
   bit                 hold_request;
   int                 mismatches;
   int                 quiet_cycles;

   power_soft_clipper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_in(req_sample_in), .req_shape_amount(req_shape_amount),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor square root by the bitwise method.
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned rest, root, b;
      rest = x;
      root = 0;
      b = 64'd1 << 62;
      while (b > rest) b = b >> 2;
      while (b != 0) begin
         if (rest >= root + b) begin
            rest = rest - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Minus log2 of a Q20 value, as Q24, by 24 squarings of the normalised mantissa.
   function automatic longint unsigned log2_deficit(input longint unsigned v);
      longint unsigned m, frac;
      int msb;
      msb = 0;
      frac = 0;
      if (v == 0 || v >= UNIT_Q20) return 0;
      while ((v >> (msb + 1)) != 0) msb++;
      m = v << (30 - msb);
      for (int i = 0; i < 24; i++) begin
         m = (m * m + (64'd1 << 29)) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (longint'(20 - msb) << 24) - frac;
   endfunction

   // Two to the power of minus a Q24 exponent, as Q30.
   function automatic longint unsigned pow2_neg(input longint unsigned n);
      longint unsigned whole, r;
      whole = n >> 24;
      r = 64'd1 << 30;
      if (whole > 30) return 0;
      for (int k = 1; k <= 24; k++)
         if ((n >> (24 - k)) & 64'd1) r = (r * half_roots[k] + (64'd1 << 29)) >> 30;
      return r >> whole;
   endfunction

   // Fill the roots and the x(1 - ln x) curve the same way the block's ROMs hold them.
   function automatic void build_curve();
      longint unsigned step, x, n, e;
      step = CURVE_DEPTH - 2;
      half_roots[0] = 64'd1 << 30;
      half_roots[1] = floor_sqrt(64'd1 << 59);
      for (int j = 2; j <= 24; j++) half_roots[j] = floor_sqrt(half_roots[j-1] << 30);
      for (int k = 0; k < CURVE_DEPTH; k++) begin
         if (k == 0) begin
            curve_rom[k] = 0;
         end else if (k >= step) begin
            curve_rom[k] = UNIT_Q20;
         end else begin
            x = (longint'(k) * (UNIT_Q20 * 2) + step) / (2 * step);
            n = (log2_deficit(x) * LOG_E2_Q30 + (64'd1 << 29)) >> 30;
            e = (x * ((64'd1 << 24) + n) + (64'd1 << 23)) >> 24;
            curve_rom[k] = (e > UNIT_Q20) ? UNIT_Q20 : e;
         end
      end
   endfunction

   // The clipped sample that one request should give.
   function automatic logic signed [21:0] clipped_sample(input logic signed [23:0] s,
                                                         input logic signed [20:0] f);
      longint sv, fv;
      longint unsigned a, mag, pos, j, r, q, p, lhs, rhs, num, d;
      mode_type mode;
      sv = s;
      fv = f;
      a = (sv < 0) ? longint'(-sv) : longint'(sv);
      if (a > UNIT_Q20) a = UNIT_Q20;
      if (fv <= 0) mode = MODE_HARD;
      else if (fv >= longint'(UNIT_Q16)) mode = MODE_TABLE;
      else if (a == 0) mode = MODE_ZERO;
      else mode = MODE_POWER;
      case (mode)
         MODE_HARD: mag = a;
         MODE_ZERO: mag = 0;
         MODE_TABLE: begin
            pos = a * (CURVE_DEPTH - 2);
            j = pos >> 20;
            r = pos & (UNIT_Q20 - 1);
            if (j > CURVE_DEPTH - 2) j = CURVE_DEPTH - 2;
            mag = (curve_rom[j] * (UNIT_Q20 - r) + curve_rom[j+1] * r + (64'd1 << 19)) >> 20;
         end
         default: begin
            q = (log2_deficit(a) << 16) / longint'(fv);
            p = pow2_neg(q);
            lhs = a << 26;
            rhs = longint'(fv) * p;
            num = (lhs > rhs) ? lhs - rhs : 0;
            d = UNIT_Q16 - longint'(fv);
            mag = (num + (d << 9)) / (d << 10);
            if (mag > UNIT_Q20) mag = UNIT_Q20;
         end
      endcase
      return (sv < 0) ? -22'(mag) : 22'(mag);
   endfunction

   // Record the expected result of every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         clipped_due.push_back(clipped_sample(req_sample_in, req_shape_amount));
   end

   // Compare every accepted result with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clipped_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result %0d with none expected", rsp_sample_out);
         end else begin
            if (rsp_sample_out !== clipped_due[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample_out mismatch: expected %0d, got %0d",
                           clipped_due[0], rsp_sample_out);
            end
            void'(clipped_due.pop_front());
         end
      end
   end

   // Receiver stalls at random, or holds off for a long stretch when asked.
   always @(posedge clock) begin
      int held;
      if (reset) begin
         rsp_stall <= 1'b0;
         held = 0;
      end else if (hold_request) begin
         rsp_stall <= 1'b1;
         held++;
         if (held >= HOLD_CYCLES) begin
            hold_request = 1'b0;
            held = 0;
         end
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog on cycles in which neither side moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one request, with a random gap first, and wait until it is taken.
   task automatic send_request(input logic signed [23:0] s, input logic signed [20:0] f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      req_shape_amount <= f;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(2097152)) - 1048576);
         2: return 24'($signed($urandom_range(2048)) - 1024);
         default: return 24'($signed($urandom_range(64)) - 32 +
                             ($urandom_range(1) ? 1048576 : -1048576));
      endcase
   endfunction

   function automatic logic signed [20:0] random_shape();
      case ($urandom_range(5))
         0: return 21'($urandom);
         1: return -21'($urandom_range(1048576));
         2: return 21'($urandom_range(1048575, 65536));
         3: return 21'($urandom_range(65535, 65500));
         default: return 21'($urandom_range(65535, 1));
      endcase
   endfunction

   // Extremes of both fields, each shape mode, zero and the clamp edges.
   task automatic test_extremes();
      logic signed [23:0] samples [10];
      logic signed [20:0] shapes [7];
      samples = '{-24'sd8388608, 24'sd8388607, 24'sd0, 24'sd1, -24'sd1, 24'sd1048576,
                  -24'sd1048576, 24'sd1048577, -24'sd1048575, 24'sd524288};
      shapes = '{-21'sd1048576, 21'sd0, 21'sd1, 21'sd32768, 21'sd65535, 21'sd65536,
                 21'sd1048575};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < 10; i++) send_request(samples[i], shapes[i % 7]);
      for (int i = 0; i < 7; i++) send_request(samples[(i * 3) % 10], shapes[i]);
      for (int i = 0; i < 7; i++) send_request(samples[6 - i], shapes[6 - i]);
   endtask

   // Random requests under one idling mix.
   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_request(random_sample(), random_shape());
   endtask

   // The receiver holds off while requests keep coming, so the input stalls.
   task automatic test_result_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 1'b1;
      for (int i = 0; i < 150; i++) send_request(random_sample(), random_shape());
   endtask

   initial begin
      build_curve();
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      req_shape_amount = '0;
      hold_request = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      mismatches = 0;
      quiet_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random_mix(130, 0, 0);
      test_random_mix(130, 58, 0);
      test_random_mix(130, 0, 58);
      test_random_mix(130, 29, 29);
      test_result_hold_off();
      req_valid <= 1'b0;
      rsp_stall_pct = 20;
      while (clipped_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
